>>> rtl/mersenne_twister_generator_assert.svh
// Assertion helpers for the twister generator; clk and rst_n in scope.
`ifndef MERSENNE_TWISTER_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_pkg
// Constants, types and tempering for the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned TBL    = 624;
  localparam int unsigned TBL_AW = 10;
  localparam int unsigned SHOFS  = 397;

  localparam logic [31:0] TW_MAT    = 32'h9908_b0df;
  localparam logic [31:0] HI_BIT    = 32'h8000_0000;
  localparam logic [31:0] LO_BITS   = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MUL  = 32'd1812433253;
  localparam logic [31:0] KEY_MUL1  = 32'd1664525;
  localparam logic [31:0] KEY_MUL2  = 32'd1566083941;
  localparam logic [31:0] KEY_BASE  = 32'd19650218;
  localparam logic [31:0] DEF_SEED  = 32'd5489;
  localparam logic [31:0] TMP_B     = 32'h9d2c_5680;
  localparam logic [31:0] TMP_C     = 32'hefc6_0000;

  typedef logic [TBL_AW-1:0] tbl_addr_t;

  typedef enum logic [1:0] {
    FN_SEED = 2'd0,
    FN_KEY  = 2'd1,
    FN_GEN  = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  typedef struct packed {
    logic      we;
    tbl_addr_t addr;
    logic [31:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic      re;
    tbl_addr_t addr;
  } tbl_rd_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TMP_B);
    y = y ^ ((y << 15) & TMP_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

>>> rtl/mtg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_in_if / mtg_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] seed_value;
  logic [31:0] key_word;
  logic        key_last;
  modport source (output valid, func, seed_value, key_word, key_last, input ready);
  modport sink   (input valid, func, seed_value, key_word, key_last, output ready);
endinterface

interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;
  modport source (output valid, random_word, input ready);
  modport sink   (input valid, random_word, output ready);
endinterface

>>> rtl/mtg_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_table_ram
// 624 x 32 state table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mtg_table_ram
  import mtg_pkg::*;
(
  input  logic        clk,
  input  tbl_wr_t     wr,
  input  tbl_rd_t     rd_a,
  input  tbl_rd_t     rd_b,
  output logic [31:0] rdata_a,
  output logic [31:0] rdata_b
);

  logic [31:0] mem [TBL];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_a.re) begin
      rdata_a <= mem[rd_a.addr];
    end
    if (rd_b.re) begin
      rdata_b <= mem[rd_b.addr];
    end
  end

endmodule

>>> rtl/mersenne_twister_generator.sv
`timescale 1ns / 1ps
// Generate: accept, table read, temper into the result register (waits while it
//   is full); no new command is taken until then. Every 624th word adds a twist
//   pass (read, then mix and write per entry on the single table write port).
// Seed: multiply then add/write per entry. Last key word: seed plus two key
//   passes. Other key words are stored and the block goes back to idle.
// Reset (sync, active low) clears control and restores the default seed only; read index starts at "not seeded".
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator: seed, key load and generate commands over a state table.
// ----------------------------------------------------------------------------
module mersenne_twister_generator
  import mtg_pkg::*;
#(
  parameter int unsigned MAX_KEY_WORDS = 16
)
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata,
  mtg_in_if.sink          in_ch,
  mtg_out_if.source       out_ch
);

`include "mersenne_twister_generator_assert.svh"

  // key store sizing: count holds 0..MAX, index holds 0..MAX-1
  localparam int unsigned KCW = $clog2(MAX_KEY_WORDS + 1);
  localparam int unsigned KJW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam tbl_addr_t   LAST = tbl_addr_t'(TBL - 1);
  localparam tbl_addr_t   IDX_TOP = tbl_addr_t'(TBL);
  localparam tbl_addr_t   IDX_UNSEEDED = tbl_addr_t'(TBL + 1);
  localparam tbl_addr_t   TW_SPLIT = tbl_addr_t'(TBL - SHOFS);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_SINIT = 14'b00000000000010,  // write t[0] = seed
    ST_SMUL  = 14'b00000000000100,  // seed recurrence multiply
    ST_SWR   = 14'b00000000001000,  // seed recurrence add + write
    ST_KRD   = 14'b00000000010000,  // key pass: read t[i], key[j], multiply
    ST_KWR   = 14'b00000000100000,  // key pass: combine + write
    ST_KFIX  = 14'b00000001000000,  // wrap: t[0] = t[623]
    ST_KEND  = 14'b00000010000000,  // t[0] = 0x80000000
    ST_TPRE  = 14'b00000100000000,  // twist: read t[0]
    ST_TLD   = 14'b00001000000000,  // twist: latch t[0]
    ST_TRD   = 14'b00010000000000,  // twist: read t[n+1], t[n+397]
    ST_TWR   = 14'b00100000000000,  // twist: mix + write
    ST_GRD   = 14'b01000000000000,  // read t[index]
    ST_GWR   = 14'b10000000000000   // temper into output register
  } state_t;

  typedef enum logic [2:0] {
    AFT_IDLE  = 3'b001,
    AFT_KEY   = 3'b010,
    AFT_TWIST = 3'b100
  } after_t;

  state_t         state_r, state_nxt;
  after_t         aft_r, aft_nxt;
  tbl_addr_t      idx_r, idx_nxt;       // read index
  tbl_addr_t      n_r, n_nxt;           // entry pointer of the running pass
  tbl_addr_t      cnt_r, cnt_nxt;       // steps done in key pass
  logic           pass_r, pass_nxt;     // key pass 0/1
  logic [KJW-1:0] j_r, j_nxt;
  logic [KCW-1:0] kcnt_r, kcnt_nxt;
  logic [KCW-1:0] klen_r, klen_nxt;
  logic [31:0]    seed_r, seed_nxt;
  logic [31:0]    p_r, p_nxt;           // last written / current word
  logic [31:0]    prod_r, prod_nxt;
  logic [31:0]    dseed_r;
  logic           ov_r, ov_nxt;
  logic [31:0]    od_r, od_nxt;

  tbl_wr_t     twr;
  tbl_rd_t     trd_a, trd_b;
  logic [31:0] rd_a, rd_b;

  logic [31:0]    key_mem [MAX_KEY_WORDS];
  logic [31:0]    key_rd;
  logic           key_we;

  logic           in_acc;
  logic [31:0]    pmix, kx, mixy;
  tbl_addr_t      tw_b;
  logic [KCW-1:0] kcnt_inc;

  mtg_table_ram u_ram (
    .clk     (clk),
    .wr      (twr),
    .rd_a    (trd_a),
    .rd_b    (trd_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = ov_r;
  assign out_ch.random_word = od_r;

  assign pmix     = p_r ^ (p_r >> 30);
  assign kx       = rd_a ^ prod_r;
  assign mixy     = (p_r & HI_BIT) | (rd_a & LO_BITS);
  assign tw_b     = (n_r < TW_SPLIT) ? tbl_addr_t'(n_r + tbl_addr_t'(SHOFS))
                                     : tbl_addr_t'(n_r - TW_SPLIT);
  assign kcnt_inc = KCW'(kcnt_r + KCW'(1));
  assign key_we   = in_acc && (func_t'(in_ch.func) == FN_KEY) &&
                    (kcnt_r < KCW'(MAX_KEY_WORDS));

  // key store: one write at the fill count, registered read at j
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[kcnt_r[KJW-1:0]] <= in_ch.key_word;
    end
    if (state_r == ST_KRD) begin
      key_rd <= key_mem[j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dseed_r <= DEF_SEED;
    end else if (cfg_we) begin
      dseed_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    aft_nxt   = aft_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    j_nxt     = j_r;
    kcnt_nxt  = kcnt_r;
    klen_nxt  = klen_r;
    seed_nxt  = seed_r;
    p_nxt     = p_r;
    prod_nxt  = prod_r;
    ov_nxt    = ov_r && !out_ch.ready;
    od_nxt    = od_r;
    twr       = '{we: 1'b0, addr: n_r, data: p_r};
    trd_a     = '{re: 1'b0, addr: n_r};
    trd_b     = '{re: 1'b0, addr: tw_b};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (func_t'(in_ch.func))
            FN_SEED: begin
              kcnt_nxt  = '0;
              seed_nxt  = in_ch.seed_value;
              aft_nxt   = AFT_IDLE;
              state_nxt = ST_SINIT;
            end
            FN_KEY: begin
              if (kcnt_r < KCW'(MAX_KEY_WORDS)) begin
                kcnt_nxt = kcnt_inc;
              end
              if (in_ch.key_last) begin
                klen_nxt  = (kcnt_r < KCW'(MAX_KEY_WORDS)) ? kcnt_inc : kcnt_r;
                kcnt_nxt  = '0;
                seed_nxt  = KEY_BASE;
                aft_nxt   = AFT_KEY;
                state_nxt = ST_SINIT;
              end
            end
            FN_GEN: begin
              if (idx_r == IDX_TOP) begin
                state_nxt = ST_TPRE;
              end else if (idx_r > IDX_TOP) begin
                seed_nxt  = dseed_r;
                aft_nxt   = AFT_TWIST;
                state_nxt = ST_SINIT;
              end else begin
                state_nxt = ST_GRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SINIT: begin
        twr       = '{we: 1'b1, addr: '0, data: seed_r};
        p_nxt     = seed_r;
        n_nxt     = tbl_addr_t'(1);
        state_nxt = ST_SMUL;
      end
      ST_SMUL: begin
        prod_nxt  = pmix * SEED_MUL;
        state_nxt = ST_SWR;
      end
      ST_SWR: begin
        p_nxt = prod_r + 32'(n_r);
        twr   = '{we: 1'b1, addr: n_r, data: p_nxt};
        if (n_r == LAST) begin
          idx_nxt = IDX_TOP;
          case (aft_r)
            AFT_KEY: begin
              // key pass starts at i = 1, so the previous word is t[0]
              p_nxt     = seed_r;
              n_nxt     = tbl_addr_t'(1);
              j_nxt     = '0;
              cnt_nxt   = '0;
              pass_nxt  = 1'b0;
              state_nxt = ST_KRD;
            end
            AFT_TWIST: state_nxt = ST_TPRE;
            default:   state_nxt = ST_IDLE;
          endcase
        end else begin
          n_nxt     = tbl_addr_t'(n_r + tbl_addr_t'(1));
          state_nxt = ST_SMUL;
        end
      end
      ST_KRD: begin
        trd_a     = '{re: 1'b1, addr: n_r};
        prod_nxt  = pmix * (pass_r ? KEY_MUL2 : KEY_MUL1);
        state_nxt = ST_KWR;
      end
      ST_KWR: begin
        p_nxt   = pass_r ? (kx - 32'(n_r)) : (kx + key_rd + 32'(j_r));
        twr     = '{we: 1'b1, addr: n_r, data: p_nxt};
        cnt_nxt = tbl_addr_t'(cnt_r + tbl_addr_t'(1));
        n_nxt   = tbl_addr_t'(n_r + tbl_addr_t'(1));
        j_nxt   = (KCW'(j_r) + KCW'(1) >= klen_r) ? '0 : KJW'(j_r + KJW'(1));
        if (n_r == LAST) begin
          state_nxt = ST_KFIX;
        end else if (!pass_r && cnt_nxt == IDX_TOP) begin
          pass_nxt  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_KRD;
        end else if (pass_r && cnt_nxt == LAST) begin
          state_nxt = ST_KEND;
        end else begin
          state_nxt = ST_KRD;
        end
      end
      ST_KFIX: begin
        twr   = '{we: 1'b1, addr: '0, data: p_r};
        n_nxt = tbl_addr_t'(1);
        if (!pass_r && cnt_r == IDX_TOP) begin
          pass_nxt  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_KRD;
        end else if (pass_r && cnt_r == LAST) begin
          state_nxt = ST_KEND;
        end else begin
          state_nxt = ST_KRD;
        end
      end
      ST_KEND: begin
        twr       = '{we: 1'b1, addr: '0, data: HI_BIT};
        idx_nxt   = IDX_TOP;
        state_nxt = ST_IDLE;
      end
      ST_TPRE: begin
        trd_a     = '{re: 1'b1, addr: '0};
        n_nxt     = '0;
        state_nxt = ST_TLD;
      end
      ST_TLD: begin
        p_nxt     = rd_a;
        state_nxt = ST_TRD;
      end
      ST_TRD: begin
        trd_a     = '{re: 1'b1,
                      addr: (n_r == LAST) ? '0 : tbl_addr_t'(n_r + tbl_addr_t'(1))};
        trd_b     = '{re: 1'b1, addr: tw_b};
        state_nxt = ST_TWR;
      end
      ST_TWR: begin
        twr   = '{we: 1'b1, addr: n_r,
                  data: rd_b ^ (mixy >> 1) ^ (mixy[0] ? TW_MAT : '0)};
        p_nxt = rd_a;
        if (n_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = ST_GRD;
        end else begin
          n_nxt     = tbl_addr_t'(n_r + tbl_addr_t'(1));
          state_nxt = ST_TRD;
        end
      end
      ST_GRD: begin
        trd_a     = '{re: 1'b1, addr: idx_r};
        idx_nxt   = tbl_addr_t'(idx_r + tbl_addr_t'(1));
        state_nxt = ST_GWR;
      end
      ST_GWR: begin
        // hold the word here until the output register frees up
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          od_nxt    = temper(rd_a);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      aft_r   <= AFT_IDLE;
      idx_r   <= IDX_UNSEEDED;
      kcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      aft_r   <= aft_nxt;
      idx_r   <= idx_nxt;
      kcnt_r  <= kcnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    cnt_r  <= cnt_nxt;
    pass_r <= pass_nxt;
    j_r    <= j_nxt;
    klen_r <= klen_nxt;
    seed_r <= seed_nxt;
    p_r    <= p_nxt;
    prod_r <= prod_nxt;
    od_r   <= od_nxt;
  end

  `MTG_ASSERT_IMP(a_gen_in_range, state_r == ST_GRD, idx_r < IDX_TOP, "read past table")
  `MTG_ASSERT_NXT(a_key_end_idx, state_r == ST_KEND, idx_r == IDX_TOP, "key end index")
  `MTG_ASSERT_IMP(a_key_len, state_r == ST_KRD, klen_r != '0, "empty key pass")
  `MTG_ASSERT_NXT(a_twist_done, state_r == ST_TWR && n_r == LAST, idx_r == '0,
                  "twist end index")

endmodule
